/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lsmq_pkg.sv */
// ----------------------------------------------------------------------------
// lsmq_pkg
// Shared types and codes for the merge-based priority queue.
// ----------------------------------------------------------------------------
package lsmq_pkg;

  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int STATUS_W  = 2;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK,
    S_MSETUP,
    S_MFETCH,
    S_MEMIT,
    S_MDONE,
    S_HCHK,
    S_WBSETUP,
    S_WBFETCH,
    S_WBWRITE,
    S_SFETCH,
    S_SCMP,
    S_SEVAL,
    S_POP,
    S_DECIDE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_INS,
    PH_HALF1,
    PH_HALF2
  } phase_t;

  typedef struct packed {
    logic    load;
    logic    seed;
    logic    mrg_setup;
    logic    mrg_emit;
    logic    mrg_done;
    logic    lvl_inc;
    logic    lvl_dec;
    logic    lvl_free;
    logic    wb_setup;
    logic    wb_write;
    logic    scan_fetch;
    logic    scan_cmp;
    logic    pop;
    logic    cnt_inc;
    logic    result;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic live_lvl;
    logic lvl_top;
    logic mrg_empty;
    logic mrg_last;
    logic wb_empty;
    logic wb_last;
    logic scan_last;
    logic found;
    logic pop_free;
    logic need_halve;
    logic out_free;
  } stat_t;

endpackage

/* rtl/lsmq_in_if.sv */
// ----------------------------------------------------------------------------
// lsmq_in_if
// Request channel: operation and key with valid/ready.
// ----------------------------------------------------------------------------
interface lsmq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [lsmq_pkg::IN_KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

/* rtl/lsmq_out_if.sv */
// ----------------------------------------------------------------------------
// lsmq_out_if
// Result channel: removed key and status with valid/ready.
// ----------------------------------------------------------------------------
interface lsmq_out_if;
  logic                           valid;
  logic                           ready;
  logic [lsmq_pkg::OUT_KEY_W-1:0] min_key;
  logic [lsmq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output min_key, output status, input ready);
  modport sink (input valid, input min_key, input status, output ready);
endinterface

/* rtl/lsmq_ctrl.sv */
// ----------------------------------------------------------------------------
// lsmq_ctrl
// Sequencer: steps inserts, carry merges, head scans, pops and rebalancing.
// ----------------------------------------------------------------------------
module lsmq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lsmq_pkg::stat_t stat,
  output lsmq_pkg::cmd_t  cmd
);
  import lsmq_pkg::*;

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_INS;
      res_r   <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        phase_nxt = PH_INS;
        if (stat.op == OP_REMOVE) begin
          state_nxt = S_SFETCH;
        end else if (stat.full) begin
          res_nxt   = ST_FULL;
          state_nxt = S_RESULT;
        end else begin
          cmd.seed  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.live_lvl && !stat.lvl_top) begin
          state_nxt = S_MSETUP;
        end else begin
          state_nxt = S_WBSETUP;
        end
      end
      S_MSETUP: begin
        cmd.mrg_setup = 1'b1;
        state_nxt     = S_MFETCH;
      end
      S_MFETCH: begin
        state_nxt = stat.mrg_empty ? S_MDONE : S_MEMIT;
      end
      S_MEMIT: begin
        cmd.mrg_emit = 1'b1;
        state_nxt    = stat.mrg_last ? S_MDONE : S_MFETCH;
      end
      S_MDONE: begin
        cmd.mrg_done = 1'b1;
        unique case (phase_r)
          PH_INS: begin
            cmd.lvl_inc = 1'b1;
            state_nxt   = S_CHK;
          end
          PH_HALF1: begin
            cmd.lvl_dec = 1'b1;
            state_nxt   = S_HCHK;
          end
          default: begin
            cmd.lvl_inc = 1'b1;
            state_nxt   = S_WBSETUP;
          end
        endcase
      end
      S_HCHK: begin
        // merge the halved block into a live lower neighbor, else drop it there
        if (stat.live_lvl) begin
          phase_nxt = PH_HALF2;
          state_nxt = S_MSETUP;
        end else begin
          state_nxt = S_WBSETUP;
        end
      end
      S_WBSETUP: begin
        cmd.wb_setup = 1'b1;
        if (stat.wb_empty) begin
          res_nxt   = (phase_r == PH_INS) ? ST_INSERTED : ST_REMOVED;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_WBFETCH;
        end
      end
      S_WBFETCH: begin
        state_nxt = S_WBWRITE;
      end
      S_WBWRITE: begin
        cmd.wb_write = 1'b1;
        if (stat.wb_last) begin
          res_nxt   = (phase_r == PH_INS) ? ST_INSERTED : ST_REMOVED;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_WBFETCH;
        end
      end
      S_SFETCH: begin
        cmd.scan_fetch = 1'b1;
        state_nxt      = S_SCMP;
      end
      S_SCMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = stat.scan_last ? S_SEVAL : S_SFETCH;
      end
      S_SEVAL: begin
        if (stat.found) begin
          state_nxt = S_POP;
        end else begin
          res_nxt   = ST_EMPTY;
          state_nxt = S_RESULT;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        res_nxt = ST_REMOVED;
        if (stat.pop_free) begin
          cmd.lvl_free = 1'b1;
          state_nxt    = S_RESULT;
        end else if (stat.need_halve) begin
          phase_nxt = PH_HALF1;
          state_nxt = S_MSETUP;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.result  = 1'b1;
          cmd.status  = res_r;
          cmd.cnt_inc = (res_r == ST_INSERTED);
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lsmq_dp.sv */
// ----------------------------------------------------------------------------
// lsmq_dp
// Datapath: key store, merge scratch banks, level table and result register.
// ----------------------------------------------------------------------------
module lsmq_dp #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_operation,
  input  logic [lsmq_pkg::IN_KEY_W-1:0]   in_key,
  input  lsmq_pkg::cmd_t                  cmd,
  output lsmq_pkg::stat_t                 stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [lsmq_pkg::OUT_KEY_W-1:0]  out_min_key,
  output logic [lsmq_pkg::STATUS_W-1:0]   out_status
);
  import lsmq_pkg::*;

  localparam int LEVELS      = $clog2(CAPACITY) + 1;
  localparam int LW          = $clog2(LEVELS);
  localparam int AW          = LEVELS;
  localparam int STORE_DEPTH = 1 << LEVELS;
  localparam int CW          = $clog2(CAPACITY + 1);

  // key store: level i lives at [2^i, 2^(i+1)); scratch: two banks of 2^(LEVELS-1)
  logic [KEY_WIDTH-1:0] store_mem [STORE_DEPTH];
  logic [KEY_WIDTH-1:0] scr_mem [STORE_DEPTH];

  logic                 op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [LW-1:0]        lvl_r;
  logic                 live_r [LEVELS];
  logic [AW-1:0]        first_r [LEVELS];
  logic [AW-1:0]        size_r [LEVELS];
  logic [CW-1:0]        count_r;
  logic                 bank_r;
  logic [AW-1:0]        cntb_r;
  logic [AW-1:0]        ia_r, ib_r, na_r, nb_r, abase_r;
  logic [LW-1:0]        best_r, head_r;
  logic [KEY_WIDTH-1:0] best_key_r;
  logic                 found_r, headf_r;
  logic [KEY_WIDTH-1:0] store_q_r, scr_q_r;
  logic                 out_valid_r;
  logic [OUT_KEY_W-1:0] out_min_key_r;
  status_t              out_status_r;

  logic [AW-1:0]        lvl_base;
  logic [AW-1:0]        store_raddr;
  logic [AW-1:0]        merge_k;
  logic                 take_a;
  logic                 scr_we;
  logic [AW-1:0]        scr_waddr;
  logic [KEY_WIDTH-1:0] scr_wdata;

  assign lvl_base    = AW'(1) << lvl_r;
  assign store_raddr = cmd.scan_fetch ? (lvl_base + first_r[lvl_r]) : (abase_r + ia_r);
  assign merge_k     = ia_r + ib_r;
  assign take_a      = (ia_r < na_r) && ((ib_r >= nb_r) || (store_q_r < scr_q_r));

  always_comb begin
    scr_we    = cmd.seed | cmd.mrg_emit;
    scr_waddr = {~bank_r, merge_k[AW-2:0]};
    scr_wdata = take_a ? store_q_r : scr_q_r;
    if (cmd.seed) begin
      scr_waddr = {bank_r, {(AW-1){1'b0}}};
      scr_wdata = key_r;
    end
  end

  always_ff @(posedge clk) begin
    store_q_r <= store_mem[store_raddr];
    if (cmd.wb_write) begin
      store_mem[lvl_base + ib_r] <= scr_q_r;
    end
  end

  always_ff @(posedge clk) begin
    scr_q_r <= scr_mem[{bank_r, ib_r[AW-2:0]}];
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        live_r[i]  <= 1'b0;
        first_r[i] <= '0;
        size_r[i]  <= '0;
      end
      count_r     <= '0;
      lvl_r       <= '0;
      bank_r      <= 1'b0;
      cntb_r      <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      found_r     <= 1'b0;
      headf_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r    <= in_operation;
        key_r   <= KEY_WIDTH'(in_key);
        lvl_r   <= '0;
        found_r <= 1'b0;
        headf_r <= 1'b0;
      end
      if (cmd.seed) begin
        cntb_r <= AW'(1);
      end
      // take the level into the merge as source A and free it
      if (cmd.mrg_setup) begin
        na_r            <= live_r[lvl_r] ? size_r[lvl_r] : '0;
        nb_r            <= cntb_r;
        ia_r            <= '0;
        ib_r            <= '0;
        abase_r         <= lvl_base + first_r[lvl_r];
        live_r[lvl_r]   <= 1'b0;
        first_r[lvl_r]  <= '0;
        size_r[lvl_r]   <= '0;
      end
      if (cmd.mrg_emit) begin
        if (take_a) begin
          ia_r <= ia_r + AW'(1);
        end else begin
          ib_r <= ib_r + AW'(1);
        end
      end
      if (cmd.mrg_done) begin
        bank_r <= ~bank_r;
        cntb_r <= merge_k;
      end
      if (cmd.lvl_inc) begin
        lvl_r <= lvl_r + LW'(1);
      end
      if (cmd.lvl_dec) begin
        lvl_r <= lvl_r - LW'(1);
      end
      if (cmd.lvl_free) begin
        live_r[lvl_r]  <= 1'b0;
        first_r[lvl_r] <= '0;
      end
      if (cmd.wb_setup) begin
        ib_r           <= '0;
        first_r[lvl_r] <= '0;
        size_r[lvl_r]  <= cntb_r;
        live_r[lvl_r]  <= (cntb_r != '0);
      end
      if (cmd.wb_write) begin
        ib_r <= ib_r + AW'(1);
      end
      if (cmd.scan_cmp) begin
        if (live_r[lvl_r] && (size_r[lvl_r] != '0)) begin
          if (!headf_r) begin
            head_r  <= lvl_r;
            headf_r <= 1'b1;
          end
          // keep the first strictly smallest head
          if (!found_r || (store_q_r < best_key_r)) begin
            best_r     <= lvl_r;
            best_key_r <= store_q_r;
            found_r    <= 1'b1;
          end
        end
        if (lvl_r != LW'(LEVELS - 1)) begin
          lvl_r <= lvl_r + LW'(1);
        end
      end
      if (cmd.pop) begin
        lvl_r           <= best_r;
        first_r[best_r] <= first_r[best_r] + AW'(1);
        size_r[best_r]  <= size_r[best_r] - AW'(1);
        cntb_r          <= '0;
        if (count_r != '0) begin
          count_r <= count_r - CW'(1);
        end
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.result) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= cmd.status;
        out_min_key_r <= (cmd.status == ST_REMOVED) ? OUT_KEY_W'(best_key_r) : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.full       = (count_r >= CW'(CAPACITY));
    stat.live_lvl   = live_r[lvl_r];
    stat.lvl_top    = (lvl_r == LW'(LEVELS - 1));
    stat.mrg_empty  = ({1'b0, na_r} + {1'b0, nb_r}) == '0;
    stat.mrg_last   = ({1'b0, merge_k} + (AW + 1)'(1)) == ({1'b0, na_r} + {1'b0, nb_r});
    stat.wb_empty   = (cntb_r == '0);
    stat.wb_last    = ((ib_r + AW'(1)) == cntb_r);
    stat.scan_last  = (lvl_r == LW'(LEVELS - 1));
    stat.found      = found_r;
    stat.pop_free   = (size_r[lvl_r] == '0) && (lvl_r == head_r);
    stat.need_halve = (lvl_r != '0) && (size_r[lvl_r] < (lvl_base >> 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_min_key = out_min_key_r;
  assign out_status  = out_status_r;

endmodule

/* rtl/lsm_priority_queue.sv */
// ----------------------------------------------------------------------------
// lsm_priority_queue
// Bounded min-priority queue built from sorted power-of-two blocks.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: operation 0 inserts key,
//   operation 1 removes the smallest key. out_ch returns exactly one result
//   per request: status inserted, removed (min_key holds the key), empty or
//   full (key dropped). min_key is zero unless status is removed.
//   One request is processed at a time; in_ready is high only when idle and
//   returns in the cycle the result is posted.
//   An insert whose level is taken merges that level's block with its own
//   and carries upward until a free level takes the merged block, which is
//   written back there. A block that drops below half its level after a
//   remove is moved down and merged with a live lower neighbor.
//   The result sits in an output register: a stalled receiver holds it, and
//   the next request is still taken; its result waits until the register
//   frees. Reset (synchronous, active low) empties the queue at once.
// ----------------------------------------------------------------------------
module lsm_priority_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input logic     clk,
  input logic     rst_n,
  lsmq_in_if.sink in_ch,
  lsmq_out_if.source out_ch
);
  import lsmq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsmq_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_min_key  (out_ch.min_key),
    .out_status   (out_ch.status)
  );

endmodule

/* rtl/lsmq_checker.sv */
// ----------------------------------------------------------------------------
// lsmq_checker
// Port-level checks on the queue's request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsmq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lsmq_pkg::OUT_KEY_W-1:0] out_min_key,
  input logic [lsmq_pkg::STATUS_W-1:0]  out_status
);
  import lsmq_pkg::*;

  // one request in flight: ready drops after each accepted transaction
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  `ASSERT_IMPL(a_key_zero, clk, rst_n, out_valid && (out_status != ST_REMOVED), out_min_key == '0)

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_min_key))

  // a result can only appear while the sequencer is busy, never when idle before
  `ASSERT_NEXT(a_rise_busy, clk, rst_n, !out_valid && in_ready && !in_valid, !out_valid)

endmodule

bind lsm_priority_queue lsmq_checker u_lsmq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_min_key (out_ch.min_key),
  .out_status  (out_ch.status)
);
